FILE: hdl/tdp_pkg.sv
// Shared types and constants for the trial division prime test.
// Used by tdp_div_serial and trial_division_prime_test; no dependencies.
package tdp_pkg;

	localparam int CAND_W = 32;

	typedef struct packed {
		logic start;
	} tdp_div_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} tdp_div_stat_t;

endpackage

FILE: hdl/tdp_div_serial.sv
// Radix-2 restoring divider producing one quotient bit per cycle.
// Depends on tdp_pkg for its control and status structs.
module tdp_div_serial
	import tdp_pkg::*;
#(
	parameter int W = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  tdp_div_ctl_t  ctl,
	input  logic [W-1:0]  dividend,
	input  logic [W-1:0]  divisor,
	output tdp_div_stat_t stat,
	output logic [W-1:0]  quotient,
	output logic [W-1:0]  remainder
);

	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  dvd_q;
	logic [W-1:0]  dsr_q;
	logic [W-1:0]  quo_q;
	logic [W:0]    rem_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [W:0]    rem_sh;
	logic [W+1:0]  diff;

	assign rem_sh = {rem_q[W-1:0], dvd_q[W-1]};
	assign diff   = {1'b0, rem_sh} - {2'b00, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !ctl.start && (cnt_q == CW'(1));
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			quo_q <= '0;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[W-2:0], 1'b0};
			if (!diff[W+1]) begin
				rem_q <= diff[W:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q[W-1:0];

endmodule

FILE: hdl/trial_division_prime_test.sv
// Trial division prime test: one candidate word in, one prime_flag word out.
// Depends on tdp_pkg and tdp_div_serial.
//
// Each candidate word is tested one at a time. Values below two and even values
// go straight to the finish state. Odd values run odd trial divisors from three
// up, each trial a full serial division in tdp_div_serial, until a divisor
// exceeds its quotient or leaves a zero remainder; a 32-bit prime takes about
// 32768 trials. Only the low VALUE_WIDTH bits of candidate are tested. A
// finished result waits in an output register, so the next candidate word is
// taken while it is unclaimed.
module trial_division_prime_test
	import tdp_pkg::*;
#(
	parameter int VALUE_WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [CAND_W-1:0] candidate,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              prime_flag
);

	localparam int VW = VALUE_WIDTH;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_START  = 2'd1;
	localparam logic [1:0] ST_WAIT   = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	logic [1:0]    state_q;
	logic [VW-1:0] val_q;
	logic [VW-1:0] dsr_q;
	logic          flag_q;
	logic          out_valid_q;
	logic          prime_flag_q;
	logic [VW-1:0] cand_v;
	logic [VW-1:0] quo;
	logic [VW-1:0] rem;
	logic          out_free;
	tdp_div_ctl_t  div_ctl;
	tdp_div_stat_t div_stat;

	generate
		if (VW <= CAND_W) begin : g_trunc
			assign cand_v = candidate[VW-1:0];
		end else begin : g_ext
			assign cand_v = {{(VW - CAND_W){1'b0}}, candidate};
		end
	endgenerate

	assign in_ready      = (state_q == ST_IDLE);
	assign out_free      = !out_valid_q || out_ready;
	assign div_ctl.start = (state_q == ST_START);

	tdp_div_serial #(
		.W(VW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.dividend (val_q),
		.divisor  (dsr_q),
		.stat     (div_stat),
		.quotient (quo),
		.remainder(rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (cand_v[VW-1:1] == '0 || !cand_v[0]) begin
							state_q <= ST_FINISH;
						end else begin
							state_q <= ST_START;
						end
					end
				end
				ST_START: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (div_stat.done) begin
						if (dsr_q > quo || rem == '0) begin
							state_q <= ST_FINISH;
						end else begin
							state_q <= ST_START;
						end
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				val_q <= cand_v;
				dsr_q <= VW'(3);
				if (cand_v[VW-1:1] == '0) begin
					flag_q <= 1'b0;
				end else begin
					flag_q <= (cand_v == VW'(2));
				end
			end
			ST_WAIT: begin
				if (div_stat.done) begin
					if (dsr_q > quo) begin
						flag_q <= 1'b1;
					end else if (rem == '0) begin
						flag_q <= 1'b0;
					end else begin
						dsr_q <= dsr_q + VW'(2);
					end
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					prime_flag_q <= flag_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid  = out_valid_q;
	assign prime_flag = prime_flag_q;

`ifndef ASSERT_OFF
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> state_q == ST_WAIT)
		else $error("divider done outside wait state");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_START |=> div_stat.busy)
		else $error("divider not busy after start");

	a_odd_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WAIT |-> dsr_q[0] && dsr_q >= VW'(3))
		else $error("trial divisor not odd or below three");

	a_result_load: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FINISH && out_free |=> out_valid && prime_flag == $past(flag_q))
		else $error("result word not loaded");
`endif

endmodule
